// File: hdl/dqid_pkg.sv
// Shared types and constants for the deque with indexed delete.
// No dependencies; imported by the controller, the datapath and the top level.
package dqid_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned VAL_W = 30;
  localparam int unsigned POS_W = 30;

  // Request codes; code 3 only triggers a dump.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DUMP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture input beat
    logic update;  // apply request to the list
    logic step;    // emit one result beat
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;  // output register can take a beat this cycle
    logic last_beat;  // beat at the cursor is the final one of the request
  } sts_t;

endpackage

// File: hdl/dqid_ctrl.sv
// Sequencer for the deque: accept, update, then dump the list.
// Depends on dqid_pkg.
module dqid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dqid_pkg::sts_t  sts_i,
  output dqid_pkg::cmd_t  cmd_o
);
  import dqid_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DUMP;
      end
      ST_DUMP: begin
        cmd_o.step = sts_i.slot_free;
        if (sts_i.slot_free && sts_i.last_beat) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/dqid_datapath.sv
// List storage, request latch, dump cursor and output register for the deque.
// Depends on dqid_pkg; driven by dqid_ctrl through cmd_t / sts_t.
module dqid_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dqid_pkg::cmd_t              cmd_i,
  output dqid_pkg::sts_t              sts_o,
  input  logic [dqid_pkg::OP_W-1:0]   operation_i,
  input  logic [dqid_pkg::VAL_W-1:0]  value_i,
  input  logic [dqid_pkg::POS_W-1:0]  position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        direction_o,
  output logic [dqid_pkg::VAL_W-1:0]  element_o,
  output logic                        line_empty_o,
  output logic                        line_end_o,
  output logic                        dropped_o,
  output logic                        last_o
);
  import dqid_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Request latch (payload, no reset)
  logic [OP_W-1:0]  op_q;
  logic [VAL_W-1:0] val_q;
  logic [POS_W-1:0] pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
  end

  logic [CNT_W-1:0] count_q, count_d;
  logic             drop_q, drop_d;
  logic             is_push, full, do_push, do_del;

  assign is_push = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
  assign full    = (count_q == CNT_W'(DEPTH));
  assign do_push = is_push && !full;
  assign do_del  = (op_q == OP_DELETE) && (pos_q < POS_W'(count_q));

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (cmd_i.update) begin
      drop_d = is_push && full;
      if (do_push) begin
        count_d = count_q + CNT_W'(1);
      end else if (do_del) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  // Entry storage: every entry picks its own next value in parallel
  logic [VAL_W-1:0] entries_q [DEPTH];
  logic [VAL_W-1:0] ent_d     [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    logic [VAL_W-1:0] prev_val, next_val;
    if (g == 0) begin : g_first
      assign prev_val = val_q;
    end else begin : g_mid
      assign prev_val = entries_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_val = entries_q[g];
    end else begin : g_inner
      assign next_val = entries_q[g+1];
    end

    always_comb begin
      ent_d[g] = entries_q[g];
      if (do_push && (op_q == OP_PUSH_FRONT)) begin
        ent_d[g] = prev_val;
      end else if (do_push && (op_q == OP_PUSH_BACK)) begin
        if (CNT_W'(g) == count_q) begin
          ent_d[g] = val_q;
        end
      end else if (do_del) begin
        if (POS_W'(g) >= pos_q) begin
          ent_d[g] = next_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      entries_q <= ent_d;
    end
  end

  // Dump cursor
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             dir_q, dir_d;
  logic [CNT_W-1:0] cnt_m1;
  logic             empty, line_end;

  assign cnt_m1   = count_q - CNT_W'(1);
  assign empty    = (count_q == '0);
  assign line_end = empty || (dir_q ? (idx_q == '0) : (CNT_W'(idx_q) == cnt_m1));

  always_comb begin
    idx_d = idx_q;
    dir_d = dir_q;
    if (cmd_i.update) begin
      idx_d = '0;
      dir_d = 1'b0;
    end else if (cmd_i.step) begin
      if (!dir_q) begin
        if (line_end) begin
          dir_d = 1'b1;
          idx_d = empty ? '0 : cnt_m1[IDX_W-1:0];
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end else if (!line_end) begin
        idx_d = idx_q - IDX_W'(1);
      end
    end
  end

  // Output register
  logic             out_valid_q, out_valid_d;
  logic             dir_out_q;
  logic [VAL_W-1:0] elem_out_q;
  logic             empty_out_q, end_out_q, drop_out_q, last_out_q;

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.last_beat = dir_q && line_end;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drop_q      <= drop_d;
      idx_q       <= idx_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      dir_out_q   <= dir_q;
      elem_out_q  <= empty ? '0 : entries_q[idx_q];
      empty_out_q <= empty;
      end_out_q   <= line_end;
      drop_out_q  <= drop_q;
      last_out_q  <= dir_q && line_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign direction_o  = dir_out_q;
  assign element_o    = elem_out_q;
  assign line_empty_o = empty_out_q;
  assign line_end_o   = end_out_q;
  assign dropped_o    = drop_out_q;
  assign last_o       = last_out_q;

endmodule

// File: hdl/deque_with_indexed_delete_top.sv
// Deque with indexed delete, top level: controller plus datapath.
// First result beat is registered once the request is latched and the list updated.
// One request at a time: a new one is taken only after the dump of the last one ends;
// the dump sends one result beat per cycle while the single output register is free.
// Reset (rst_ni low, asynchronous): list empty, controller idle, no beat pending.
// Depends on dqid_pkg, dqid_ctrl and dqid_datapath.
module deque_with_indexed_delete_top #(
  parameter int unsigned DEPTH = 16  // list capacity, 1..32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dqid_pkg::OP_W-1:0]   operation_i,
  input  logic [dqid_pkg::VAL_W-1:0]  value_i,
  input  logic [dqid_pkg::POS_W-1:0]  position_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        direction_o,
  output logic [dqid_pkg::VAL_W-1:0]  element_o,
  output logic                        line_empty_o,
  output logic                        line_end_o,
  output logic                        dropped_o,
  output logic                        last_o
);
  import dqid_pkg::*;

  // Controller: IDLE takes a request beat, UPDATE applies the push or
  // delete to the list (all entries update in parallel), DUMP
  // walks the list front to back then back to front, one beat per cycle
  // whenever the output register is free.
  cmd_t cmd;
  sts_t sts;

  dqid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: entry registers, count, dump cursor and the output register.
  // The output register lets a new request be taken while the final beat of
  // the previous one still waits for the sink.
  dqid_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .direction_o  (direction_o),
    .element_o    (element_o),
    .line_empty_o (line_empty_o),
    .line_end_o   (line_end_o),
    .dropped_o    (dropped_o),
    .last_o       (last_o)
  );

  // One request in flight: after an accept the controller is busy.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && cmd.update))
    else $error("request accepted while previous one still being processed");

  // Final beat of a request closes the backward direction.
  a_last_closes_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (direction_o && line_end_o))
    else $error("last beat not at end of backward dump");

  // Empty marker carries no element and ends its direction.
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_empty_o) |-> (line_end_o && (element_o == '0)))
    else $error("malformed empty-list marker");

  // The datapath only gets a step when the output register has room.
  a_step_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> (!out_valid_o || out_ready_i))
    else $error("result beat overwrote a pending one");

endmodule
